### design/bmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_pkg: shared types and constants of the box mean filter
// Pixel and result word formats, register map, lane/merge control records.
// ----------------------------------------------------------------------------
package bmf_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_WINDOW_DEF = 21;
	localparam int HEIGHT_LIMIT   = 1024;
	localparam int ROW_W          = 10;
	localparam int RESULT_LIMIT   = 11;
	localparam int PIX_W          = 24;
	localparam int ADDR_W         = 4;

	localparam logic [10:0] WIDTH_RST  = 11'd640;
	localparam logic [10:0] HEIGHT_RST = 11'd480;
	localparam logic [4:0]  WINDOW_RST = 5'd9;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_WINDOW_SIZE  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic       action;
		logic [7:0] blue_in;
		logic [7:0] green_in;
		logic [7:0] red_in;
	} pix_t;

	typedef struct packed {
		logic [7:0] mean_blue;
		logic [7:0] mean_green;
		logic [7:0] mean_red;
		logic       last_of_run;
		logic       end_of_frame;
	} res_t;

	typedef struct packed {
		logic issue;
		logic clear;
		logic div_start;
	} merge_ctl_t;

	typedef struct packed {
		logic busy;
		logic div_busy;
	} merge_sts_t;

endpackage

### design/bmf_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_lane: one line of the window store
// Holds one buffered row, reads one column a cycle while re is high and scales by row weight.
// ----------------------------------------------------------------------------
module bmf_lane #(
	parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF,
	parameter int WW        = 5
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(MAX_WIDTH)-1:0]    waddr,
	input  logic [bmf_pkg::PIX_W-1:0]       wdata,
	input  logic                            re,
	input  logic [$clog2(MAX_WIDTH)-1:0]    raddr,
	input  logic [WW-1:0]                   weight,
	output logic [2:0][8+WW-1:0]            prod
);
	import bmf_pkg::*;

	localparam int PRW = 8 + WW;

	logic [PIX_W-1:0] mem [MAX_WIDTH];
	logic [PIX_W-1:0] rdata_s1;
	logic [2:0][PRW-1:0] prod_s2;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// scale by how many window rows map onto this line; a line outside the
	// window adds nothing, whatever its storage holds
	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			if (weight == '0) begin
				prod_s2[ch] <= '0;
			end else begin
				prod_s2[ch] <= PRW'(rdata_s1[8*ch +: 8]) * PRW'(weight);
			end
		end
	end

	assign prod = prod_s2;

endmodule

### design/bmf_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_merge: lane merge, window accumulator and mean divider
// Adds the lane products, accumulates columns, divides by the window area.
// ----------------------------------------------------------------------------
module bmf_merge #(
	parameter int NL    = bmf_pkg::MAX_WINDOW_DEF,
	parameter int PRW   = 13,
	parameter int SUM_W = 17,
	parameter int AW    = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bmf_pkg::merge_ctl_t         ctl,
	input  logic [NL-1:0][2:0][PRW-1:0] prod,
	input  logic [AW-1:0]               area,
	output bmf_pkg::merge_sts_t         sts,
	output logic [2:0][7:0]             mean
);
	import bmf_pkg::*;

	localparam int XW = (SUM_W > AW + 8) ? SUM_W : AW + 8;

	logic v_s1, v_s2, v_s3;
	logic [2:0][SUM_W-1:0] sum_c;
	logic [2:0][SUM_W-1:0] sum_s3;
	logic [2:0][SUM_W-1:0] acc_q;
	logic [2:0][XW-1:0] rem_q;
	logic [XW-1:0] dsh_q;
	logic [3:0] cnt_q;
	logic div_busy_q;
	logic [2:0][7:0] quo_q;

	always_comb begin
		sum_c = '0;
		for (int l = 0; l < NL; l++) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum_c[ch] = sum_c[ch] + SUM_W'(prod[l][ch]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			div_busy_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (ctl.div_start) begin
				div_busy_q <= 1'b1;
				cnt_q      <= 4'd8;
			end else if (div_busy_q) begin
				cnt_q      <= cnt_q - 4'd1;
				div_busy_q <= (cnt_q != 4'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= sum_c;
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (v_s3) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc_q[ch] <= acc_q[ch] + sum_s3[ch];
			end
		end
		// restoring division, one quotient bit a cycle; the mean fits a byte
		if (ctl.div_start) begin
			for (int ch = 0; ch < 3; ch++) begin
				rem_q[ch] <= XW'(acc_q[ch]);
			end
			dsh_q <= XW'(area) << 7;
			quo_q <= '0;
		end else if (div_busy_q) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (rem_q[ch] >= dsh_q) begin
					rem_q[ch] <= rem_q[ch] - dsh_q;
					quo_q[ch] <= {quo_q[ch][6:0], 1'b1};
				end else begin
					quo_q[ch] <= {quo_q[ch][6:0], 1'b0};
				end
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign sts.busy     = v_s1 | v_s2 | v_s3;
	assign sts.div_busy = div_busy_q;
	assign mean         = quo_q;

endmodule

### design/box_mean_filter_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_mean_filter_rgb: streaming RGB box mean filter, mirrored borders
// Raster pixels in, per-channel window means out, one bank per buffered row.
// ----------------------------------------------------------------------------
//  port group   dir   word       handshake
//  pix          in    pix_t      pix_valid / pix_ready
//  res          out   res_t      res_valid / res_ready
//  apb          in    32b regs   psel / penable / pwrite, pready tied high
//
// One word is taken at a time; each result is paced by the row-weight pass,
// the lane pipe, the divider and the single column read port per bank.
// Up to eleven results follow a pixel, at most one follows a drain word.
// A stalled res word holds the block; reset clears counters, not the store.
// ----------------------------------------------------------------------------
module box_mean_filter_rgb #(
	parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_WINDOW = bmf_pkg::MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pix_valid,
	output logic                       pix_ready,
	input  bmf_pkg::pix_t              pix,
	output logic                       res_valid,
	input  logic                       res_ready,
	output bmf_pkg::res_t              res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bmf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import bmf_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int CWW   = CW + 1;
	localparam int BW    = $clog2(MAX_WINDOW);
	localparam int PMAX  = (MAX_WINDOW - 1) / 2;
	localparam int PW    = $clog2(MAX_WINDOW);
	localparam int DW    = $clog2(MAX_WINDOW + 1);
	localparam int WW    = DW;
	localparam int PRW   = 8 + WW;
	localparam int SUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
	localparam int AW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
	localparam int RIW   = ROW_W + 3;
	localparam int CIW   = CW + 3;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_ROWS  = 7'b0000100,
		S_COLS  = 7'b0001000,
		S_DRAIN = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [10:0] frame_width_q, frame_height_q;
	logic [4:0]  window_size_q;

	logic [ROW_W-1:0] ir_q, orow_q;
	logic [CW-1:0]    ic_q, ocol_q;
	logic [BW-1:0]    in_bank_q, obank_q;
	logic             done_q;
	logic [3:0]       n_q, limit_q;
	logic [DW-1:0]    dr_q, dc_q;
	logic signed [RIW-1:0] ridx_q;
	logic signed [CIW-1:0] cidx_q;
	logic [WW-1:0]    weight_q [MAX_WINDOW];

	logic [CWW-1:0] w_eff;
	logic [10:0]    h_eff;
	logic [3:0]     pad_half;
	logic [PW-1:0]  pad_eff;
	logic [DW-1:0]  side;
	logic [AW-1:0]  area;

	logic cfg_wr, pix_acc, pix_write;

	// effective frame geometry
	always_comb begin
		if (frame_width_q == 11'd0) begin
			w_eff = CWW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = CWW'(MAX_WIDTH);
		end else begin
			w_eff = CWW'(frame_width_q);
		end
		if (frame_height_q == 11'd0) begin
			h_eff = 11'd1;
		end else if (32'(frame_height_q) > HEIGHT_LIMIT) begin
			h_eff = 11'(HEIGHT_LIMIT);
		end else begin
			h_eff = frame_height_q;
		end
		pad_half = 4'((window_size_q | 5'd1) >> 1);
		if (32'(pad_half) > PMAX) begin
			pad_eff = PW'(PMAX);
		end else begin
			pad_eff = PW'(pad_half);
		end
		side = DW'({pad_eff, 1'b1});
		area = AW'(side) * AW'(side);
	end

	function automatic logic ready_at(
		input logic [ROW_W-1:0] r,
		input logic [CW-1:0]    c,
		input logic [ROW_W-1:0] ir,
		input logic [CW-1:0]    ic,
		input logic             done,
		input logic [PW-1:0]    pad,
		input logic [10:0]      h,
		input logic [CWW-1:0]   w
	);
		logic [ROW_W+1:0] nr, hm;
		logic [CW+1:0]    nc, wm;
		hm = (ROW_W+2)'(h) - (ROW_W+2)'(1);
		nr = (ROW_W+2)'(r) + (ROW_W+2)'(pad);
		if (nr > hm) nr = hm;
		wm = (CW+2)'(w) - (CW+2)'(1);
		nc = (CW+2)'(c) + (CW+2)'(pad);
		if (nc > wm) nc = wm;
		return done || (nr < (ROW_W+2)'(ir)) ||
			(nr == (ROW_W+2)'(ir) && nc < (CW+2)'(ic));
	endfunction

	// position bookkeeping
	logic [CW-1:0]    w_m1;
	logic [10:0]      h_m1;
	logic             ocol_last, orow_last, eof, last;
	logic [ROW_W-1:0] orow_nx;
	logic [CW-1:0]    ocol_nx;
	logic             ready_now, ready_nx;

	always_comb begin
		w_m1      = CW'(w_eff - CWW'(1));
		h_m1      = h_eff - 11'd1;
		ocol_last = (ocol_q == w_m1);
		orow_last = (11'(orow_q) == h_m1);
		eof       = ocol_last && orow_last;
		orow_nx   = ocol_last ? orow_q + ROW_W'(1) : orow_q;
		ocol_nx   = ocol_last ? '0 : ocol_q + CW'(1);
		ready_now = ready_at(orow_q, ocol_q, ir_q, ic_q, done_q, pad_eff, h_eff, w_eff);
		ready_nx  = ready_at(orow_nx, ocol_nx, ir_q, ic_q, done_q, pad_eff, h_eff, w_eff);
		last      = eof || (n_q + 4'd1 == limit_q) || !ready_nx;
	end

	// row mirror and bank select
	logic signed [RIW-1:0] h_s, orow_s, pad_rs, row_val, row_refl, bsum, bfix, ridx_nx;
	logic                  row_in;
	logic [BW-1:0]         row_bank;

	always_comb begin
		h_s      = $signed(RIW'(h_eff));
		orow_s   = $signed(RIW'(orow_q));
		pad_rs   = $signed(RIW'(pad_eff));
		row_in   = (h_eff <= 11'd1) || (ridx_q >= 0 && ridx_q < h_s);
		row_val  = (h_eff <= 11'd1) ? '0 : ridx_q;
		row_refl = (ridx_q < 0) ? -ridx_q : h_s + h_s - ridx_q - $signed(RIW'(2));
		bsum     = $signed(RIW'(obank_q)) + row_val - orow_s;
		if (bsum < 0) begin
			bfix = bsum + $signed(RIW'(MAX_WINDOW));
		end else if (bsum >= $signed(RIW'(MAX_WINDOW))) begin
			bfix = bsum - $signed(RIW'(MAX_WINDOW));
		end else begin
			bfix = bsum;
		end
		row_bank = bfix[BW-1:0];
		ridx_nx  = orow_s - pad_rs + $signed(RIW'(dr_q)) + $signed(RIW'(1));
	end

	// column mirror
	logic signed [CIW-1:0] w_s, ocol_s, pad_cs, col_refl, cidx_nx;
	logic                  col_in;
	logic [CW-1:0]         col_val;

	always_comb begin
		w_s      = $signed(CIW'(w_eff));
		ocol_s   = $signed(CIW'(ocol_q));
		pad_cs   = $signed(CIW'(pad_eff));
		col_in   = (w_eff <= CWW'(1)) || (cidx_q >= 0 && cidx_q < w_s);
		col_val  = (w_eff <= CWW'(1)) ? '0 : cidx_q[CW-1:0];
		col_refl = (cidx_q < 0) ? -cidx_q : w_s + w_s - cidx_q - $signed(CIW'(2));
		cidx_nx  = ocol_s - pad_cs + $signed(CIW'(dc_q)) + $signed(CIW'(1));
	end

	merge_ctl_t mctl;
	merge_sts_t msts;
	logic [2:0][7:0] mean;

	assign pix_ready = (state_q == S_IDLE);
	assign pix_acc   = pix_valid && pix_ready;
	assign pix_write = pix_acc && !pix.action && !done_q;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign res_valid = (state_q == S_OUT);

	always_comb begin
		mctl.issue     = (state_q == S_COLS) && col_in;
		mctl.clear     = (state_q == S_CHECK);
		mctl.div_start = (state_q == S_DRAIN) && !msts.busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
			window_size_q  <= WINDOW_RST;
			ir_q           <= '0;
			ic_q           <= '0;
			orow_q         <= '0;
			ocol_q         <= '0;
			in_bank_q      <= '0;
			obank_q        <= '0;
			done_q         <= 1'b0;
			n_q            <= '0;
			limit_q        <= 4'd1;
			dr_q           <= '0;
			dc_q           <= '0;
			ridx_q         <= '0;
			cidx_q         <= '0;
		end else begin
			if (cfg_wr) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_FRAME_WIDTH: begin
						frame_width_q <= pwdata[10:0];
					end
					REG_FRAME_HEIGHT: begin
						frame_height_q <= pwdata[10:0];
					end
					REG_WINDOW_SIZE: begin
						window_size_q <= pwdata[4:0];
					end
					default: begin
					end
				endcase
				if (reg_idx_t'(paddr[3:2]) == REG_FRAME_WIDTH ||
					reg_idx_t'(paddr[3:2]) == REG_FRAME_HEIGHT ||
					reg_idx_t'(paddr[3:2]) == REG_WINDOW_SIZE) begin
					ir_q      <= '0;
					ic_q      <= '0;
					orow_q    <= '0;
					ocol_q    <= '0;
					in_bank_q <= '0;
					obank_q   <= '0;
					done_q    <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (pix_acc) begin
						n_q     <= '0;
						limit_q <= pix.action ? 4'd1 : 4'(RESULT_LIMIT);
						if (pix.action) begin
							state_q <= S_CHECK;
						end else if (!done_q) begin
							state_q <= S_CHECK;
							if (ic_q == w_m1) begin
								ic_q <= '0;
								if (11'(ir_q) == h_m1) begin
									ir_q      <= '0;
									in_bank_q <= '0;
									done_q    <= 1'b1;
								end else begin
									ir_q      <= ir_q + ROW_W'(1);
									in_bank_q <= (in_bank_q == BW'(MAX_WINDOW - 1)) ?
										'0 : in_bank_q + BW'(1);
								end
							end else begin
								ic_q <= ic_q + CW'(1);
							end
						end
					end
				end
				S_CHECK: begin
					if (ready_now && n_q < limit_q) begin
						dr_q    <= '0;
						ridx_q  <= orow_s - pad_rs;
						state_q <= S_ROWS;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ROWS: begin
					if (row_in) begin
						if (dr_q == side - DW'(1)) begin
							dc_q    <= '0;
							cidx_q  <= ocol_s - pad_cs;
							state_q <= S_COLS;
						end else begin
							dr_q   <= dr_q + DW'(1);
							ridx_q <= ridx_nx;
						end
					end else begin
						ridx_q <= row_refl;
					end
				end
				S_COLS: begin
					if (col_in) begin
						if (dc_q == side - DW'(1)) begin
							state_q <= S_DRAIN;
						end else begin
							dc_q   <= dc_q + DW'(1);
							cidx_q <= cidx_nx;
						end
					end else begin
						cidx_q <= col_refl;
					end
				end
				S_DRAIN: begin
					if (!msts.busy) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!msts.div_busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_ready) begin
						n_q     <= n_q + 4'd1;
						state_q <= S_CHECK;
						if (eof) begin
							ir_q      <= '0;
							ic_q      <= '0;
							orow_q    <= '0;
							ocol_q    <= '0;
							in_bank_q <= '0;
							obank_q   <= '0;
							done_q    <= 1'b0;
						end else begin
							ocol_q <= ocol_nx;
							orow_q <= orow_nx;
							if (ocol_last) begin
								obank_q <= (obank_q == BW'(MAX_WINDOW - 1)) ?
									'0 : obank_q + BW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// row weights: how many window rows land on each bank
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			for (int l = 0; l < MAX_WINDOW; l++) begin
				weight_q[l] <= '0;
			end
		end else if (state_q == S_ROWS && row_in) begin
			weight_q[row_bank] <= weight_q[row_bank] + WW'(1);
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			REG_WINDOW_SIZE:  prdata = 32'(window_size_q);
			default:          prdata = '0;
		endcase
	end

	logic [MAX_WINDOW-1:0][2:0][PRW-1:0] lane_prod;

	for (genvar l = 0; l < MAX_WINDOW; l++) begin : g_lane
		bmf_lane #(
			.MAX_WIDTH (MAX_WIDTH),
			.WW        (WW)
		) u_lane (
			.clk    (clk),
			.we     (pix_write && in_bank_q == BW'(l)),
			.waddr  (ic_q),
			.wdata  ({pix.red_in, pix.green_in, pix.blue_in}),
			.re     (mctl.issue),
			.raddr  (col_val),
			.weight (weight_q[l]),
			.prod   (lane_prod[l])
		);
	end

	bmf_merge #(
		.NL    (MAX_WINDOW),
		.PRW   (PRW),
		.SUM_W (SUM_W),
		.AW    (AW)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.prod   (lane_prod),
		.area   (area),
		.sts    (msts),
		.mean   (mean)
	);

	always_comb begin
		res.mean_blue    = mean[0];
		res.mean_green   = mean[1];
		res.mean_red     = mean[2];
		res.last_of_run  = last;
		res.end_of_frame = eof;
	end

	logic [DW+BW-1:0] weight_total;

	always_comb begin
		weight_total = '0;
		for (int l = 0; l < MAX_WINDOW; l++) begin
			weight_total = weight_total + (DW+BW)'(weight_q[l]);
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready |-> !res_valid)
		else $error("input taken while a result is pending");

	a_weights: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COLS |-> weight_total == (DW+BW)'(side))
		else $error("row weights do not cover the window side");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.end_of_frame |-> res.last_of_run)
		else $error("frame end not marked as last of run");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> n_q < limit_q)
		else $error("result burst exceeds its limit");

endmodule
